[rtl/yc2rgb_pkg.sv]
// ----------------------------------------------------------------------------
// yc2rgb_pkg
// Shared widths, coefficient reset values, register indexes and the types
// that travel between the stages of the YCbCr to RGB converter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package yc2rgb_pkg;

  // field widths
  localparam int PIX_W   = 8;
  localparam int COEF_W  = 16;
  localparam int Y_W     = PIX_W + 1;   // luma minus 16 spans -16..239
  localparam int C_W     = PIX_W;       // chroma minus 128 spans -128..127
  localparam int FRAC_SH = 16;          // Q16 coefficients
  localparam int YP_W    = Y_W + COEF_W;
  localparam int CP_W    = C_W + COEF_W;
  // channel sums stay within about +-700, so 12 bits never saturate at 16
  localparam int SUM_W   = 12;
  localparam int CFG_IDX_W = 3;

  // input offsets
  localparam logic [Y_W-1:0] LUMA_OFS   = Y_W'(16);
  localparam logic [C_W-1:0] CHROMA_OFS = C_W'(128);

  // coefficient reset values
  localparam logic signed [COEF_W-1:0] R_LUMA_RST = COEF_W'(10773);
  localparam logic signed [COEF_W-1:0] R_CR_RST   = COEF_W'(6293);
  localparam logic signed [COEF_W-1:0] G_LUMA_RST = COEF_W'(10773);
  localparam logic signed [COEF_W-1:0] G_CB_RST   = COEF_W'(-25674);
  localparam logic signed [COEF_W-1:0] G_CR_RST   = COEF_W'(-20511);
  localparam logic signed [COEF_W-1:0] B_LUMA_RST = COEF_W'(10773);
  localparam logic signed [COEF_W-1:0] B_CB_RST   = COEF_W'(1129);

  // register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_R_LUMA = 3'd0,
    REG_R_CR   = 3'd1,
    REG_G_LUMA = 3'd2,
    REG_G_CB   = 3'd3,
    REG_G_CR   = 3'd4,
    REG_B_LUMA = 3'd5,
    REG_B_CB   = 3'd6
  } cfg_reg_t;

  // coefficient set
  typedef struct packed {
    logic signed [COEF_W-1:0] r_luma;
    logic signed [COEF_W-1:0] r_cr;
    logic signed [COEF_W-1:0] g_luma;
    logic signed [COEF_W-1:0] g_cb;
    logic signed [COEF_W-1:0] g_cr;
    logic signed [COEF_W-1:0] b_luma;
    logic signed [COEF_W-1:0] b_cb;
  } coef_t;

  // offset samples plus the fractional gain terms
  typedef struct packed {
    logic signed [Y_W-1:0] y;
    logic signed [C_W-1:0] cb;
    logic signed [C_W-1:0] cr;
    logic signed [Y_W-1:0] r_y;
    logic signed [C_W-1:0] r_cr;
    logic signed [Y_W-1:0] g_y;
    logic signed [C_W-1:0] g_cb;
    logic signed [C_W-1:0] g_cr;
    logic signed [Y_W-1:0] b_y;
    logic signed [C_W-1:0] b_cb;
  } term_t;

endpackage

`default_nettype wire

[rtl/yc2rgb_cfg.sv]
// ----------------------------------------------------------------------------
// yc2rgb_cfg
// Coefficient register file; writes to an index past the list are dropped.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module yc2rgb_cfg
  import yc2rgb_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [COEF_W-1:0]    cfg_data,
  output coef_t                     coef
);

  coef_t coef_r, coef_nxt;

  assign cfg_ready = 1'b1;
  assign coef      = coef_r;

  // register write decode
  always_comb begin
    coef_nxt = coef_r;
    if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_R_LUMA: coef_nxt.r_luma = cfg_data;
        REG_R_CR:   coef_nxt.r_cr   = cfg_data;
        REG_G_LUMA: coef_nxt.g_luma = cfg_data;
        REG_G_CB:   coef_nxt.g_cb   = cfg_data;
        REG_G_CR:   coef_nxt.g_cr   = cfg_data;
        REG_B_LUMA: coef_nxt.b_luma = cfg_data;
        REG_B_CB:   coef_nxt.b_cb   = cfg_data;
        default:    coef_nxt = coef_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_r.r_luma <= R_LUMA_RST;
      coef_r.r_cr   <= R_CR_RST;
      coef_r.g_luma <= G_LUMA_RST;
      coef_r.g_cb   <= G_CB_RST;
      coef_r.g_cr   <= G_CR_RST;
      coef_r.b_luma <= B_LUMA_RST;
      coef_r.b_cb   <= B_CB_RST;
    end else begin
      coef_r <= coef_nxt;
    end
  end

endmodule

`default_nettype wire

[rtl/yc2rgb_mul.sv]
// ----------------------------------------------------------------------------
// yc2rgb_mul
// Front two stages: offset removal, then the seven Q16 gain products with
// the floor shift by 16.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module yc2rgb_mul
  import yc2rgb_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic [PIX_W-1:0] in_luma,
  input  wire logic [PIX_W-1:0] in_chroma_blue,
  input  wire logic [PIX_W-1:0] in_chroma_red,
  input  wire coef_t            coef,
  output logic                  term_valid,
  input  wire logic             term_ready,
  output term_t                 term
);

  // stage a: offset samples
  logic                  va_r;
  logic signed [Y_W-1:0] y_r;
  logic signed [C_W-1:0] cb_r;
  logic signed [C_W-1:0] cr_r;
  logic                  ready_a;

  // stage b: gain terms
  logic  vb_r;
  term_t term_r, term_nxt;
  logic  ready_b;

  logic signed [YP_W-1:0] p_ry, p_gy, p_by;
  logic signed [CP_W-1:0] p_rcr, p_gcb, p_gcr, p_bcb;

  assign ready_b  = !vb_r || term_ready;
  assign ready_a  = !va_r || ready_b;
  assign in_ready = ready_a;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
    end else if (ready_a) begin
      va_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_a && in_valid) begin
      y_r  <= $signed({1'b0, in_luma} - LUMA_OFS);
      cb_r <= $signed(in_chroma_blue - CHROMA_OFS);
      cr_r <= $signed(in_chroma_red - CHROMA_OFS);
    end
  end

  // products, keep the bits above the binary point
  always_comb begin
    p_ry  = y_r  * coef.r_luma;
    p_rcr = cr_r * coef.r_cr;
    p_gy  = y_r  * coef.g_luma;
    p_gcb = cb_r * coef.g_cb;
    p_gcr = cr_r * coef.g_cr;
    p_by  = y_r  * coef.b_luma;
    p_bcb = cb_r * coef.b_cb;

    term_nxt.y    = y_r;
    term_nxt.cb   = cb_r;
    term_nxt.cr   = cr_r;
    term_nxt.r_y  = p_ry[YP_W-1:FRAC_SH];
    term_nxt.r_cr = p_rcr[CP_W-1:FRAC_SH];
    term_nxt.g_y  = p_gy[YP_W-1:FRAC_SH];
    term_nxt.g_cb = p_gcb[CP_W-1:FRAC_SH];
    term_nxt.g_cr = p_gcr[CP_W-1:FRAC_SH];
    term_nxt.b_y  = p_by[YP_W-1:FRAC_SH];
    term_nxt.b_cb = p_bcb[CP_W-1:FRAC_SH];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vb_r <= 1'b0;
    end else if (ready_b) begin
      vb_r <= va_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_b && va_r) begin
      term_r <= term_nxt;
    end
  end

  assign term_valid = vb_r;
  assign term       = term_r;

endmodule

`default_nettype wire

[rtl/yc2rgb_sum.sv]
// ----------------------------------------------------------------------------
// yc2rgb_sum
// Back two stages: the channel sums, then the clamp to 0..255 into the
// output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module yc2rgb_sum
  import yc2rgb_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              term_valid,
  output logic                   term_ready,
  input  wire term_t             term,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [PIX_W-1:0]       out_red,
  output logic [PIX_W-1:0]       out_green,
  output logic [PIX_W-1:0]       out_blue
);

  // stage c: channel sums
  logic                    vc_r;
  logic signed [SUM_W-1:0] r_sum_r, g_sum_r, b_sum_r;
  logic signed [SUM_W-1:0] r_sum_nxt, g_sum_nxt, b_sum_nxt;
  logic                    ready_c;

  // stage d: output register
  logic             vd_r;
  logic [PIX_W-1:0] red_r, green_r, blue_r;
  logic             ready_d;

  function automatic logic [PIX_W-1:0] clamp8(input logic signed [SUM_W-1:0] x);
    logic [PIX_W-1:0] res;
    if (x < 0) begin
      res = '0;
    end else if (x > SUM_W'($signed({1'b0, {PIX_W{1'b1}}}))) begin
      res = '1;
    end else begin
      res = x[PIX_W-1:0];
    end
    return res;
  endfunction

  assign ready_d    = !vd_r || out_ready;
  assign ready_c    = !vc_r || ready_d;
  assign term_ready = ready_c;

  // sums with whole-number parts of the gains
  always_comb begin
    r_sum_nxt = SUM_W'(term.y) + SUM_W'(term.r_y) + SUM_W'(term.r_cr)
              + SUM_W'(term.cr) + SUM_W'(term.cr >>> 1);
    g_sum_nxt = SUM_W'(term.y) + SUM_W'(term.g_y) + SUM_W'(term.g_cb)
              + SUM_W'(term.g_cr) - SUM_W'(term.cr >>> 1);
    b_sum_nxt = SUM_W'(term.y) + SUM_W'(term.b_y) + SUM_W'(term.b_cb)
              + (SUM_W'(term.cb) <<< 1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vc_r <= 1'b0;
    end else if (ready_c) begin
      vc_r <= term_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_c && term_valid) begin
      r_sum_r <= r_sum_nxt;
      g_sum_r <= g_sum_nxt;
      b_sum_r <= b_sum_nxt;
    end
  end

  // clamp into the output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vd_r <= 1'b0;
    end else if (ready_d) begin
      vd_r <= vc_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_d && vc_r) begin
      red_r   <= clamp8(r_sum_r);
      green_r <= clamp8(g_sum_r);
      blue_r  <= clamp8(b_sum_r);
    end
  end

  assign out_valid = vd_r;
  assign out_red   = red_r;
  assign out_green = green_r;
  assign out_blue  = blue_r;

endmodule

`default_nettype wire

[rtl/ycbcr_to_rgb_fixed.sv]
// throughput: one item per cycle while the output is not stalled; there are
// four register stages, each with its own valid
// the stages are offset removal, gain multipliers, channel sums, clamp
// a stalled output holds the last stage; earlier bubbles are still filled
// reset (rst_n low, synchronous) empties the pipeline and loads the
// default coefficients
// ----------------------------------------------------------------------------
// ycbcr_to_rgb_fixed
// Pixel converter from 8-bit YCbCr to 8-bit RGB with programmable Q16 gains.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ycbcr_to_rgb_fixed
  import yc2rgb_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [PIX_W-1:0]     in_luma,
  input  wire logic [PIX_W-1:0]     in_chroma_blue,
  input  wire logic [PIX_W-1:0]     in_chroma_red,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [PIX_W-1:0]          out_red,
  output logic [PIX_W-1:0]          out_green,
  output logic [PIX_W-1:0]          out_blue,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [COEF_W-1:0]    cfg_data
);

  coef_t coef;
  term_t term;
  logic  term_valid;
  logic  term_ready;

  // coefficient registers
  yc2rgb_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .coef      (coef)
  );

  // offsets and products
  yc2rgb_mul u_mul (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_luma        (in_luma),
    .in_chroma_blue (in_chroma_blue),
    .in_chroma_red  (in_chroma_red),
    .coef           (coef),
    .term_valid     (term_valid),
    .term_ready     (term_ready),
    .term           (term)
  );

  // sums and clamp
  yc2rgb_sum u_sum (
    .clk        (clk),
    .rst_n      (rst_n),
    .term_valid (term_valid),
    .term_ready (term_ready),
    .term       (term),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_red    (out_red),
    .out_green  (out_green),
    .out_blue   (out_blue)
  );

endmodule

`default_nettype wire

[bench/tb_ycbcr_to_rgb_fixed.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ycbcr_to_rgb_fixed
// Self-checking bench for the YCbCr to RGB pixel converter. A short table of
// corner pixels runs first, then random pixels under several gain settings
// (reset gains, all at maximum, all at minimum, all zero, random sets). Each
// accepted pixel is queued with its typed-in value or a local fixed-point
// model result, and every pixel that leaves the block is compared per channel.
// ----------------------------------------------------------------------------

module tb_ycbcr_to_rgb_fixed;
  import yc2rgb_pkg::*;

  localparam int LUMA_BLACK  = 16;
  localparam int CHROMA_MID  = 128;
  localparam int PIPE_DEPTH  = 4;
  localparam int QUIET_LIMIT = 4000;
  localparam int IDLE_PCT    = 24;
  localparam int REPORT_MAX  = 10;
  localparam int SUM_MAX     = 32767;
  localparam int SUM_MIN     = -32768;
  localparam int PIX_MAX     = 255;

  // index past the last gain register, writes to it are dropped
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

  localparam logic signed [COEF_W-1:0] GAIN_MAX = 16'sh7fff;
  localparam logic signed [COEF_W-1:0] GAIN_MIN = 16'sh8000;

  typedef struct packed {
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
  } rgb_t;

  typedef struct packed {
    logic [PIX_W-1:0] luma;
    logic [PIX_W-1:0] cb;
    logic [PIX_W-1:0] cr;
    logic             known;
    rgb_t             want;
  } pixel_row_t;

  // corner pixels, expected value typed in only where it is obvious
  localparam int DIR_N = 21;
  localparam pixel_row_t DIRECTED [DIR_N] = '{
    '{8'd16,  8'd128, 8'd128, 1'b1, 24'h000000},  // black level
    '{8'd0,   8'd128, 8'd128, 1'b1, 24'h000000},  // below black clamps to zero
    '{8'd255, 8'd128, 8'd128, 1'b1, 24'hffffff},  // above white clamps to full
    '{8'd235, 8'd128, 8'd128, 1'b0, 24'h000000},  // nominal white
    '{8'd0,   8'd0,   8'd0,   1'b0, 24'h000000},
    '{8'd255, 8'd255, 8'd255, 1'b0, 24'h000000},
    '{8'd0,   8'd255, 8'd255, 1'b0, 24'h000000},
    '{8'd255, 8'd0,   8'd0,   1'b0, 24'h000000},
    '{8'd255, 8'd0,   8'd255, 1'b0, 24'h000000},
    '{8'd255, 8'd255, 8'd0,   1'b0, 24'h000000},
    '{8'd16,  8'd0,   8'd128, 1'b0, 24'h000000},
    '{8'd16,  8'd255, 8'd128, 1'b0, 24'h000000},
    '{8'd16,  8'd128, 8'd0,   1'b0, 24'h000000},
    '{8'd16,  8'd128, 8'd255, 1'b0, 24'h000000},
    '{8'd128, 8'd128, 8'd129, 1'b0, 24'h000000},  // odd positive cr, halving rounds down
    '{8'd128, 8'd128, 8'd127, 1'b0, 24'h000000},  // odd negative cr, halving floors
    '{8'd81,  8'd90,  8'd240, 1'b0, 24'h000000},
    '{8'd145, 8'd54,  8'd34,  1'b0, 24'h000000},
    '{8'd41,  8'd240, 8'd110, 1'b0, 24'h000000},
    '{8'd170, 8'd170, 8'd170, 1'b0, 24'h000000},
    '{8'd85,  8'd85,  8'd85,  1'b0, 24'h000000}
  };

  logic                 clk;
  logic                 rst_n          = 1'b0;
  logic                 in_valid       = 1'b0;
  logic                 in_ready;
  logic [PIX_W-1:0]     in_luma        = '0;
  logic [PIX_W-1:0]     in_chroma_blue = '0;
  logic [PIX_W-1:0]     in_chroma_red  = '0;
  logic                 out_valid;
  logic                 out_ready      = 1'b0;
  logic [PIX_W-1:0]     out_red;
  logic [PIX_W-1:0]     out_green;
  logic [PIX_W-1:0]     out_blue;
  logic                 cfg_valid      = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index      = '0;
  logic [COEF_W-1:0]    cfg_data       = '0;

  // local copy of the gain registers, follows every accepted write
  coef_t gains = '{R_LUMA_RST, R_CR_RST, G_LUMA_RST, G_CB_RST,
                   G_CR_RST, B_LUMA_RST, B_CB_RST};

  rgb_t pending_rgb [$];
  int   mismatches   = 0;
  int   quiet_cycles = 0;
  logic calm         = 1'b0;

  ycbcr_to_rgb_fixed dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_luma        (in_luma),
    .in_chroma_blue (in_chroma_blue),
    .in_chroma_red  (in_chroma_red),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_red        (out_red),
    .out_green      (out_green),
    .out_blue       (out_blue),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // fixed-point conversion model
  function automatic int sat16(int v);
    if (v > SUM_MAX) return SUM_MAX;
    if (v < SUM_MIN) return SUM_MIN;
    return v;
  endfunction

  function automatic int gain_frac(int v, logic signed [COEF_W-1:0] c);
    return (v * int'(c)) >>> FRAC_SH;
  endfunction

  function automatic logic [PIX_W-1:0] clamp8(int v);
    if (v < 0) return '0;
    if (v > PIX_MAX) return '1;
    return v[PIX_W-1:0];
  endfunction

  function automatic rgb_t convert_pixel(logic [PIX_W-1:0] luma, logic [PIX_W-1:0] cb_raw,
                                         logic [PIX_W-1:0] cr_raw, coef_t k);
    int   y, cb, cr, r, g, b;
    rgb_t px;
    y  = int'(luma) - LUMA_BLACK;
    cb = int'(cb_raw) - CHROMA_MID;
    cr = int'(cr_raw) - CHROMA_MID;
    // each channel summed left to right, saturating at every step
    r = sat16(gain_frac(y, k.r_luma) + y);
    r = sat16(r + gain_frac(cr, k.r_cr));
    r = sat16(r + cr);
    r = sat16(r + (cr >>> 1));
    g = sat16(gain_frac(y, k.g_luma) + y);
    g = sat16(g + gain_frac(cb, k.g_cb));
    g = sat16(g + gain_frac(cr, k.g_cr));
    g = sat16(g - (cr >>> 1));
    b = sat16(gain_frac(y, k.b_luma) + y);
    b = sat16(b + gain_frac(cb, k.b_cb));
    b = sat16(b + cb * 2);
    px.red   = clamp8(r);
    px.green = clamp8(g);
    px.blue  = clamp8(b);
    return px;
  endfunction

  // random sample, weighted toward the ends of the range
  function automatic logic [PIX_W-1:0] pick_byte();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      default: return PIX_W'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [COEF_W-1:0] pick_gain();
    case ($urandom_range(0, 7))
      0: return GAIN_MAX;
      1: return GAIN_MIN;
      2: return '0;
      default: return COEF_W'($urandom_range(0, 65535));
    endcase
  endfunction

  task automatic flag_mismatch(string msg);
    if (mismatches < REPORT_MAX) $display("%s", msg);
    mismatches++;
  endtask

  task automatic check_channel(string name, logic [PIX_W-1:0] want, logic [PIX_W-1:0] got);
    if (got !== want)
      flag_mismatch($sformatf("%s mismatch: expected %0d, got %0d", name, want, got));
  endtask

  // one pixel item, with random idle cycles ahead of it except in calm stretches
  task automatic send_pixel(logic [PIX_W-1:0] luma, logic [PIX_W-1:0] cb,
                            logic [PIX_W-1:0] cr, logic known, rgb_t want);
    while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_luma        <= luma;
    in_chroma_blue <= cb;
    in_chroma_red  <= cr;
    do @(posedge clk); while (!in_ready);
    pending_rgb.push_back(known ? want : convert_pixel(luma, cb, cr, gains));
  endtask

  task automatic send_random(int n);
    repeat (n) send_pixel(pick_byte(), pick_byte(), pick_byte(), 1'b0, '0);
  endtask

  // leaves cfg_valid high, the caller lowers it after the last write
  task automatic write_gain(logic [CFG_IDX_W-1:0] idx, logic [COEF_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_R_LUMA: gains.r_luma = data;
      REG_R_CR:   gains.r_cr   = data;
      REG_G_LUMA: gains.g_luma = data;
      REG_G_CB:   gains.g_cb   = data;
      REG_G_CR:   gains.g_cr   = data;
      REG_B_LUMA: gains.b_luma = data;
      REG_B_CB:   gains.b_cb   = data;
      default: ;
    endcase
  endtask

  task automatic load_gains(coef_t k, logic stray);
    write_gain(REG_R_LUMA, k.r_luma);
    write_gain(REG_R_CR,   k.r_cr);
    write_gain(REG_G_LUMA, k.g_luma);
    // write past the last register, must leave every gain alone
    if (stray) write_gain(REG_UNUSED, pick_gain());
    write_gain(REG_G_CB,   k.g_cb);
    write_gain(REG_G_CR,   k.g_cr);
    write_gain(REG_B_LUMA, k.b_luma);
    write_gain(REG_B_CB,   k.b_cb);
    cfg_valid <= 1'b0;
  endtask

  // stop sending and wait until every queued pixel has come out
  task automatic drain_pixels();
    in_valid <= 1'b0;
    while (pending_rgb.size() != 0) @(posedge clk);
  endtask

  // output side stalls at random except in calm stretches
  always @(posedge clk) begin
    out_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  // compare each pixel leaving the block with the oldest expectation
  always @(posedge clk) begin
    rgb_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_rgb.size() == 0) begin
        flag_mismatch($sformatf("unexpected pixel out: %0d %0d %0d",
                                out_red, out_green, out_blue));
      end else begin
        want = pending_rgb.pop_front();
        check_channel("red", want.red, out_red);
        check_channel("green", want.green, out_green);
        check_channel("blue", want.blue, out_blue);
      end
    end
  end

  // watchdog on cycles with no item moving on any channel
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    coef_t k;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset gains: corner table, then a calm stretch, then random idling
    foreach (DIRECTED[i])
      send_pixel(DIRECTED[i].luma, DIRECTED[i].cb, DIRECTED[i].cr,
                 DIRECTED[i].known, DIRECTED[i].want);
    calm = 1'b1;
    send_random(120);
    calm = 1'b0;
    send_random(110);
    drain_pixels();

    // every gain at its extremes, then zero
    k = {7{GAIN_MAX}};
    load_gains(k, 1'b0);
    send_random(80);
    drain_pixels();

    k = {7{GAIN_MIN}};
    load_gains(k, 1'b0);
    send_random(80);
    drain_pixels();

    k = '0;
    load_gains(k, 1'b0);
    send_random(60);
    drain_pixels();

    // random gain sets, the first one with a dropped write in the middle
    for (int s = 0; s < 4; s++) begin
      k.r_luma = pick_gain();
      k.r_cr   = pick_gain();
      k.g_luma = pick_gain();
      k.g_cb   = pick_gain();
      k.g_cr   = pick_gain();
      k.b_luma = pick_gain();
      k.b_cb   = pick_gain();
      load_gains(k, s == 0);
      send_random(70);
      drain_pixels();
    end

    repeat (PIPE_DEPTH * 2) @(posedge clk);
    if (mismatches == 0 && pending_rgb.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
